// ===== sv/u2cp_pkg.sv =====
// ----------------------------------------------------------------------------
// u2cp_pkg - shared types, constants and tables
// Command word format between front and back, character codes, lead-byte
// length decode and the multi-byte character table.
// ----------------------------------------------------------------------------
package u2cp_pkg;

    localparam int unsigned SEQ_DEPTH = 6;   // longest lead-byte sequence
    localparam int unsigned Q_DEPTH   = 4;   // command queue entries
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // What the back end has to emit for one queued word
    typedef enum logic [1:0] {
        CMD_BYTE,   // one byte
        CMD_CRLF,   // CR then LF
        CMD_END     // terminating zero, marked last
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic {
        F_RUN,      // taking input words
        F_TAIL      // end of string: rerun held bytes, then terminate
    } t_front_state;

    // Total sequence length for a lead byte, 0 when not a lead
    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] k;
        k = 3'd0;
        if (c inside {[8'hC2:8'hDF]})      k = 3'd2;
        else if (c inside {[8'hE0:8'hEF]}) k = 3'd3;
        else if (c inside {[8'hF0:8'hF7]}) k = 3'd4;
        else if (c inside {[8'hF8:8'hFB]}) k = 3'd5;
        else if (c inside {[8'hFC:8'hFD]}) k = 3'd6;
        return k;
    endfunction

    // Exact match of a two- or three-byte character; '?' otherwise
    function automatic logic [7:0] char_lookup(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [2:0] len);
        logic [23:0] key;
        logic [7:0]  r;
        key = (len == 3'd3) ? {b0, b1, b2} : {8'h00, b0, b1};
        case (key)
            24'h00C387: r = 8'h80;  24'h00C3BC: r = 8'h81;  24'h00C3A9: r = 8'h82;
            24'h00C3A2: r = 8'h83;  24'h00C3A4: r = 8'h84;  24'h00C3A0: r = 8'h85;
            24'h00C3A5: r = 8'h86;  24'h00C3A7: r = 8'h87;  24'h00C3AA: r = 8'h88;
            24'h00C3AB: r = 8'h89;  24'h00C3A8: r = 8'h8A;  24'h00C3AF: r = 8'h8B;
            24'h00C3AE: r = 8'h8C;  24'h00C3AC: r = 8'h8D;  24'h00C384: r = 8'h8E;
            24'h00C78D: r = 8'h8F;  24'h00C389: r = 8'h90;  24'h00C3A6: r = 8'h91;
            24'h00C386: r = 8'h92;  24'h00C3B4: r = 8'h93;  24'h00C3B6: r = 8'h94;
            24'h00C3B2: r = 8'h95;  24'h00C3BB: r = 8'h96;  24'h00C3B9: r = 8'h97;
            24'h00C3BF: r = 8'h98;  24'h00C396: r = 8'h99;  24'h00C39C: r = 8'h9A;
            24'h00C2A2: r = 8'h9B;  24'h00C2A3: r = 8'h9C;  24'h00C2A5: r = 8'h9D;
            24'h00C39F: r = 8'h9E;  24'hE2A88D: r = 8'h9F;  24'h00C3A1: r = 8'hA0;
            24'h00C3AD: r = 8'hA1;  24'h00C3B3: r = 8'hA2;  24'h00C3BA: r = 8'hA3;
            24'h00C3B1: r = 8'hA4;  24'h00C391: r = 8'hA5;  24'h00C2AA: r = 8'hA6;
            24'h00C2BA: r = 8'hA7;  24'h00C2BF: r = 8'hA8;  24'hE28C90: r = 8'hA9;
            24'h00C2AC: r = 8'hAA;  24'h00C2BD: r = 8'hAB;  24'h00C2BC: r = 8'hAC;
            24'h00C2A1: r = 8'hAD;  24'h00C2AB: r = 8'hAE;  24'h00C2BB: r = 8'hAF;
            24'h00C3A3: r = 8'hB0;  24'h00C3B5: r = 8'hB1;  24'h00C398: r = 8'hB2;
            24'h00C3B8: r = 8'hB3;  24'h00C593: r = 8'hB4;  24'h00C592: r = 8'hB5;
            24'h00C380: r = 8'hB6;  24'h00C383: r = 8'hB7;  24'h00C395: r = 8'hB8;
            24'h00C2A8: r = 8'hB9;  24'h00C2B4: r = 8'hBA;  24'hE280A0: r = 8'hBB;
            24'h00C2B6: r = 8'hBC;  24'h00C2A9: r = 8'hBD;  24'h00C2AE: r = 8'hBE;
            24'hE284A2: r = 8'hBF;  24'h00C4B3: r = 8'hC0;  24'h00C4B2: r = 8'hC1;
            24'h00C2A7: r = 8'hDD;  24'hE2889E: r = 8'hDF;  24'h00CEB1: r = 8'hE0;
            24'h00CEB2: r = 8'hE1;  24'h00CE93: r = 8'hE2;  24'h00CF80: r = 8'hE3;
            24'h00CEA3: r = 8'hE4;  24'h00CF83: r = 8'hE5;  24'h00CEBC: r = 8'hE6;
            24'h00CF84: r = 8'hE7;  24'hE2A7B2: r = 8'hE8;  24'h00CE98: r = 8'hE9;
            24'h00CEA9: r = 8'hEA;  24'h00CEB4: r = 8'hEB;  24'hE288AE: r = 8'hEC;
            24'h00CEA6: r = 8'hED;  24'hE28888: r = 8'hEE;  24'hE288A9: r = 8'hEF;
            24'hE289A1: r = 8'hF0;  24'h00C2B1: r = 8'hF1;  24'hE289A5: r = 8'hF2;
            24'hE289A4: r = 8'hF3;  24'hE28CA0: r = 8'hF4;  24'hE28CA1: r = 8'hF5;
            24'h00C3B7: r = 8'hF6;  24'hE28988: r = 8'hF7;  24'h00C2B0: r = 8'hF8;
            24'h00CB99: r = 8'hF9;  24'hE280A2: r = 8'hFA;  24'hE2889A: r = 8'hFB;
            24'hE281BF: r = 8'hFC;  24'h00C2B2: r = 8'hFD;  24'h00C2B3: r = 8'hFE;
            default:    r = CH_QMARK;
        endcase
        if (len != 3'd2 && len != 3'd3) r = CH_QMARK;
        return r;
    endfunction

endpackage

// ===== sv/u2cp_front.sv =====
// ----------------------------------------------------------------------------
// u2cp_front - input classifier
// Takes input words, tracks the open lead-byte sequence and CR state, and
// pushes at most one command word per cycle. At end of string it reruns
// the held bytes, pausing on a full queue, then pushes the terminator.
// ----------------------------------------------------------------------------
module u2cp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic                i_q_full,
    output logic                o_push,
    output u2cp_pkg::t_cmd      o_cmd
);

    typedef struct packed {
        logic           push;
        u2cp_pkg::t_cmd cmd;
        logic           cr;
    } t_plain;

    // Top-level byte that is not a lead byte
    function automatic t_plain plain_byte(input logic [7:0] c, input logic prev_cr);
        t_plain p;
        p.push     = 1'b0;
        p.cmd.kind = u2cp_pkg::CMD_BYTE;
        p.cmd.data = c;
        p.cr       = 1'b0;
        if (c inside {[8'h20:8'h7F]} || c == u2cp_pkg::CH_TAB || c == u2cp_pkg::CH_VT) begin
            p.push = 1'b1;
        end else if (c == u2cp_pkg::CH_CR) begin
            p.push     = 1'b1;
            p.cmd.kind = u2cp_pkg::CMD_CRLF;
            p.cr       = 1'b1;
        end else if (c == u2cp_pkg::CH_LF) begin
            p.push     = !prev_cr;
            p.cmd.kind = u2cp_pkg::CMD_CRLF;
        end
        return p;
    endfunction

    u2cp_pkg::t_front_state r_state, n_state;
    logic [7:0] r_seq [u2cp_pkg::SEQ_DEPTH];
    logic [7:0] n_seq [u2cp_pkg::SEQ_DEPTH];
    logic [2:0] r_have, n_have;
    logic [2:0] r_need, n_need;
    logic       r_after_cr, n_after_cr;

    logic       fire;
    logic [2:0] k;
    logic [2:0] held;
    logic [2:0] shift;
    t_plain     pl;

    assign o_ready = (r_state == u2cp_pkg::F_RUN) && !i_q_full;
    assign fire    = i_valid && o_ready;

    always_comb begin
        n_state    = r_state;
        n_seq      = r_seq;
        n_have     = r_have;
        n_need     = r_need;
        n_after_cr = r_after_cr;
        o_push     = 1'b0;
        o_cmd.kind = u2cp_pkg::CMD_BYTE;
        o_cmd.data = u2cp_pkg::CH_QMARK;
        k          = 3'd0;
        held       = 3'd0;
        shift      = 3'd1;
        pl         = plain_byte(i_byte, r_after_cr);
        case (r_state)
            u2cp_pkg::F_RUN: begin
                if (fire) begin
                    if (r_need != 3'd0) begin
                        n_seq[r_have] = i_byte;
                        n_have        = r_have + 3'd1;
                        if (n_have >= r_need) begin
                            o_push     = 1'b1;
                            o_cmd.data = u2cp_pkg::char_lookup(r_seq[0],
                                (r_need == 3'd2) ? i_byte : r_seq[1], i_byte, r_need);
                            n_have     = 3'd0;
                            n_need     = 3'd0;
                        end
                    end else begin
                        k = u2cp_pkg::lead_len(i_byte);
                        if (k != 3'd0) begin
                            n_after_cr = 1'b0;
                            n_seq[0]   = i_byte;
                            n_have     = 3'd1;
                            n_need     = k;
                        end else begin
                            o_push     = pl.push;
                            o_cmd      = pl.cmd;
                            n_after_cr = pl.cr;
                        end
                    end
                    if (i_last) begin
                        n_after_cr = 1'b0;   // rerun starts clean
                        n_state    = u2cp_pkg::F_TAIL;
                    end
                end
            end
            u2cp_pkg::F_TAIL: begin
                if (!i_q_full) begin
                    if (r_need == 3'd0 || r_have <= 3'd1) begin
                        o_push     = 1'b1;
                        o_cmd.kind = u2cp_pkg::CMD_END;
                        o_cmd.data = u2cp_pkg::CH_NUL;
                        n_have     = 3'd0;
                        n_need     = 3'd0;
                        n_after_cr = 1'b0;
                        n_state    = u2cp_pkg::F_RUN;
                    end else begin
                        held = r_have - 3'd1;
                        k    = u2cp_pkg::lead_len(r_seq[1]);
                        if (k != 3'd0) begin
                            n_after_cr = 1'b0;
                            if (k <= held) begin
                                o_push     = 1'b1;
                                o_cmd.data = u2cp_pkg::char_lookup(r_seq[1], r_seq[2],
                                                                   r_seq[3], k);
                                shift      = k;
                            end
                        end else begin
                            pl         = plain_byte(r_seq[1], r_after_cr);
                            o_push     = pl.push;
                            o_cmd      = pl.cmd;
                            n_after_cr = pl.cr;
                        end
                        // held bytes move down; lead slot stays put
                        for (int i = 1; i < u2cp_pkg::SEQ_DEPTH; i++) begin
                            if (i + int'(shift) < u2cp_pkg::SEQ_DEPTH) begin
                                n_seq[i] = r_seq[i + int'(shift)];
                            end
                        end
                        n_have = r_have - shift;
                    end
                end
            end
            default: n_state = u2cp_pkg::F_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= u2cp_pkg::F_RUN;
            r_have     <= 3'd0;
            r_need     <= 3'd0;
            r_after_cr <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_have     <= n_have;
            r_need     <= n_need;
            r_after_cr <= n_after_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq <= n_seq;
    end

    a_need_have: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need == 3'd0) |-> (r_have == 3'd0))
        else $error("front: bytes held with no sequence open");

    a_have_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need != 3'd0) |-> (r_have != 3'd0 && r_have < r_need))
        else $error("front: held count out of step with sequence length");

    a_tail_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u2cp_pkg::F_TAIL && $past(r_state) == u2cp_pkg::F_RUN) |->
            (r_after_cr == 1'b0))
        else $error("front: rerun entered with CR state set");

endmodule

// ===== sv/u2cp_queue.sv =====
// ----------------------------------------------------------------------------
// u2cp_queue - command queue
// Small register FIFO of command words between classifier and emitter.
// ----------------------------------------------------------------------------
module u2cp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u2cp_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output u2cp_pkg::t_cmd      o_cmd,
    output logic                o_full,
    output logic                o_empty
);

    u2cp_pkg::t_cmd                   r_mem [u2cp_pkg::Q_DEPTH];
    logic [u2cp_pkg::Q_PTR_W-1:0]     r_wr, n_wr;
    logic [u2cp_pkg::Q_PTR_W-1:0]     r_rd, n_rd;
    logic [u2cp_pkg::Q_CNT_W-1:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == u2cp_pkg::Q_CNT_W'(u2cp_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + u2cp_pkg::Q_CNT_W'(i_push) - u2cp_pkg::Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue: pop while empty");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_cnt[u2cp_pkg::Q_PTR_W-1:0])
        else $error("queue: fill count disagrees with pointers");

endmodule

// ===== sv/u2cp_back.sv =====
// ----------------------------------------------------------------------------
// u2cp_back - output emitter
// Expands queued command words into output bytes, one per cycle while the
// output is accepted, into a registered output stage.
// ----------------------------------------------------------------------------
module u2cp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u2cp_pkg::t_cmd      i_cmd,
    input  logic                i_q_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last
);

    logic       r_valid, n_valid;
    logic       r_lf_pend, n_lf_pend;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_lf_pend && !i_q_empty;

    always_comb begin
        n_valid   = r_valid;
        n_lf_pend = r_lf_pend;
        n_byte    = r_byte;
        n_last    = r_last;
        if (load) begin
            n_valid = 1'b0;
            n_last  = 1'b0;
            if (r_lf_pend) begin
                n_valid   = 1'b1;
                n_byte    = u2cp_pkg::CH_LF;
                n_lf_pend = 1'b0;
            end else if (!i_q_empty) begin
                n_valid = 1'b1;
                case (i_cmd.kind)
                    u2cp_pkg::CMD_BYTE: n_byte = i_cmd.data;
                    u2cp_pkg::CMD_CRLF: begin
                        n_byte    = u2cp_pkg::CH_CR;
                        n_lf_pend = 1'b1;
                    end
                    u2cp_pkg::CMD_END: begin
                        n_byte = u2cp_pkg::CH_NUL;
                        n_last = 1'b1;
                    end
                    default: n_byte = i_cmd.data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_lf_pend <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_lf_pend <= n_lf_pend;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    a_lf_after_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lf_pend |-> (r_valid && r_byte == u2cp_pkg::CH_CR && !r_last))
        else $error("back: LF pending without CR on output");

    a_last_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_byte == u2cp_pkg::CH_NUL))
        else $error("back: last word is not the terminator");

    a_no_pop_mid_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lf_pend |-> !o_pop)
        else $error("back: queue popped while LF still owed");

endmodule

// ===== sv/utf8_to_codepage_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_to_codepage_transcoder_top - UTF-8 to 8-bit codepage transcoder
// Converts a stream of UTF-8 bytes into codepage bytes, with CR LF line
// ends and a terminating zero word at end of string.
// ----------------------------------------------------------------------------
// One input word is taken per clock while the command queue has room and
// no end-of-string rerun is running; each word yields at most one queued
// command, so input runs at one word per cycle. Output runs at one word per
// cycle while i_out_ready is high, set by the single output register: a CR
// or lone LF becomes two output words (CR LF), and the queue (four words)
// soaks up the difference until it fills and input ready drops. After the
// word marked last, input ready stays low while the classifier reruns the
// held bytes after an unfinished lead byte (0 to 4 of them) and then queues
// the terminating zero word, which leaves with o_out_last high. A held byte
// that is not a lead byte is rerun alone; a held lead byte whose whole
// sequence is held is rerun with all of its bytes; a full queue pauses the
// rerun. State then returns to its reset values for the next string.
// Printable bytes, tab and vertical tab pass; other control and stray bytes
// are dropped; two- and three-byte characters map through a fixed table,
// anything unmatched (and every longer sequence) becomes '?'.
// ----------------------------------------------------------------------------
module utf8_to_codepage_transcoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    // output words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    u2cp_pkg::t_cmd push_cmd;
    u2cp_pkg::t_cmd head_cmd;

    // classifier: sequence tracking, CR state, end-of-string rerun
    u2cp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // decouples the two sides
    u2cp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    // emitter: CR LF expansion and registered output
    u2cp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_byte    (o_out_byte),
        .o_last    (o_out_last)
    );

endmodule
